// File: rtl/lbachs_pkg.sv
// ----------------------------------------------------------------------------
// lbachs_pkg: shared types and constants for the LBA to CHS translator
// Holds the sequencer states, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package lbachs_pkg;

  // Fixed field widths of the request and result beats.
  localparam int unsigned ADDR_FIELD_W = 24;
  localparam int unsigned COUNT_W      = 8;
  localparam int unsigned TRACK_W      = 12;
  localparam int unsigned SPT_W        = 6;
  localparam int unsigned HEADS_W      = 5;
  localparam int unsigned CYL_W        = 8;
  localparam int unsigned DRIVE_W      = 2;
  localparam int unsigned HEAD_W       = 4;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 8;
  localparam int unsigned PROD_W       = HEADS_W + CYL_W;

  // Largest head count honored; larger settings are clamped to this.
  localparam logic [HEADS_W-1:0] MAX_HEADS = 5'd16;

  // Register reset values.
  localparam logic [SPT_W-1:0]   SPT_RESET   = 6'd18;
  localparam logic [HEADS_W-1:0] HEADS_RESET = 5'd2;
  localparam logic [CYL_W-1:0]   CYL_RESET   = 8'd80;
  localparam logic [DRIVE_W-1:0] DRIVE_RESET = 2'd0;

  // Commands of a request beat.
  localparam logic CMD_TRANSLATE  = 1'b0;
  localparam logic CMD_INVALIDATE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPT   = 2'd0,
    CFG_HEADS = 2'd1,
    CFG_CYL   = 2'd2,
    CFG_DRIVE = 2'd3
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_TRACK,
    ST_CHECK,
    ST_DIV_HEAD,
    ST_ASSEMBLE,
    ST_OUTPUT
  } state_e;

endpackage

// File: rtl/lba_to_chs_track_cache.sv
// ----------------------------------------------------------------------------
// lba_to_chs_track_cache: block address to cylinder/head/sector translator
// Bit-serial translation of a linear sector address with a one-track cache.
// ----------------------------------------------------------------------------
// Usage. A request beat on the input channel (in_valid_i / in_stall_o) holds a
// command, a block address and a sector count. A translate command yields one
// result beat on the output channel (out_valid_o / out_stall_i) with cylinder,
// head, one-based sector, the drive/head command byte and the count clamped to
// the end of the track, plus the track-read and out-of-range flags. An
// invalidate command drops the cached track and answers with an all-zero beat.
// Geometry is set through the configuration write port (cfg_valid_i /
// cfg_ready_o), which is always ready; write it only while the block is idle.
// The track index is found by a restoring divider that produces one quotient
// bit per cycle, one bit for each address bit used; the head/cylinder split is
// a second such divider over the 12-bit track. A range check, the assembly and
// the load of the output register follow (an out-of-range track goes from the
// check straight to the load), and the next request is taken in the same cycle
// as the result can first be taken; an invalidate or a zero geometry goes from
// idle straight to the load of the output register.
// When the receiver stalls, the output register holds its beat; the following
// result then waits in the sequencer and no new request is taken until the
// held beat is out. Reset restores the default floppy geometry and empties
// the track cache.
// ----------------------------------------------------------------------------
module lba_to_chs_track_cache #(
  parameter int unsigned ADDRESS_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic [lbachs_pkg::ADDR_FIELD_W-1:0] block_address_i,
  input  logic [lbachs_pkg::COUNT_W-1:0]      sector_count_i,
  // Result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [7:0]                          cylinder_o,
  output logic [3:0]                          head_o,
  output logic [5:0]                          sector_o,
  output logic [7:0]                          drive_head_byte_o,
  output logic [7:0]                          granted_count_o,
  output logic                                track_read_needed_o,
  output logic                                out_of_range_o,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lbachs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [lbachs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // Only the low address bits that both the field and the parameter allow
  // take part in the translation.
  localparam int unsigned AddrW = (ADDRESS_BITS < lbachs_pkg::ADDR_FIELD_W) ?
                                  ADDRESS_BITS : lbachs_pkg::ADDR_FIELD_W;
  localparam int unsigned CntW  = $clog2(AddrW);

  // Configuration registers.
  logic [lbachs_pkg::SPT_W-1:0]   spt_q;
  logic [lbachs_pkg::HEADS_W-1:0] heads_raw_q;
  logic [lbachs_pkg::CYL_W-1:0]   cyl_cnt_q;
  logic [lbachs_pkg::DRIVE_W-1:0] drive_q;

  // Track cache.
  logic [lbachs_pkg::TRACK_W-1:0] cached_track_q;
  logic                           cached_valid_q;

  // Sequencer and datapath.
  lbachs_pkg::state_e             state_q, state_d;
  logic [CntW-1:0]                cnt_q;
  logic [AddrW-1:0]               dvd_q;      // dividend in, quotient out
  logic [lbachs_pkg::SPT_W-1:0]   rem1_q;     // offset within the track
  logic [lbachs_pkg::TRACK_W-1:0] trk_q;      // track in, cylinder out
  logic [lbachs_pkg::HEAD_W-1:0]  rem2_q;     // head
  logic [lbachs_pkg::COUNT_W-1:0] count_q;
  logic [lbachs_pkg::COUNT_W-1:0] granted_q;
  logic                           need_q;

  // Pending result.
  logic [7:0] res_cyl_q;
  logic [3:0] res_head_q;
  logic [5:0] res_sector_q;
  logic [7:0] res_dh_q;
  logic [7:0] res_granted_q;
  logic       res_need_q;
  logic       res_oor_q;

  // Output register.
  logic       out_valid_q;
  logic [7:0] out_cyl_q;
  logic [3:0] out_head_q;
  logic [5:0] out_sector_q;
  logic [7:0] out_dh_q;
  logic [7:0] out_granted_q;
  logic       out_need_q;
  logic       out_oor_q;

  // Combinational helpers.
  logic                              in_accept;
  logic                              out_load;
  logic                              cnt_done;
  logic [lbachs_pkg::HEADS_W-1:0]    heads;
  logic                              zero_geom;
  logic [lbachs_pkg::SPT_W:0]        trial1;
  logic                              bit1;
  logic [lbachs_pkg::HEAD_W:0]       trial2;
  logic                              bit2;
  logic [lbachs_pkg::PROD_W-1:0]     track_limit;
  logic                              hit;
  logic                              beyond;
  logic [lbachs_pkg::SPT_W-1:0]      left;
  logic [lbachs_pkg::COUNT_W-1:0]    left_ext;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != lbachs_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == lbachs_pkg::ST_OUTPUT) && (!out_valid_q || !out_stall_i);
  assign cnt_done    = (cnt_q == '0);

  assign heads     = (heads_raw_q > lbachs_pkg::MAX_HEADS) ? lbachs_pkg::MAX_HEADS
                                                             : heads_raw_q;
  assign zero_geom = (spt_q == '0) || (heads == '0);

  // One restoring step of the track division: bring in the next address bit.
  assign trial1 = {rem1_q, dvd_q[AddrW-1]};
  assign bit1   = (trial1 >= {1'b0, spt_q});

  // One restoring step of the head division. The remainder stays below the
  // head count, so four bits hold it.
  assign trial2 = {rem2_q, trk_q[lbachs_pkg::TRACK_W-1]};
  assign bit2   = (trial2 >= heads);

  // Range check and cache lookup on the finished track index.
  assign track_limit = lbachs_pkg::PROD_W'(heads) * lbachs_pkg::PROD_W'(cyl_cnt_q);
  assign hit    = cached_valid_q &&
                  ({{(AddrW-lbachs_pkg::TRACK_W){1'b0}}, cached_track_q} == dvd_q);
  assign beyond = (dvd_q >= {{(AddrW-lbachs_pkg::PROD_W){1'b0}}, track_limit});

  // Sectors left on the track from the wanted one.
  assign left     = spt_q - rem1_q;
  assign left_ext = {{(lbachs_pkg::COUNT_W-lbachs_pkg::SPT_W){1'b0}}, left};

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lbachs_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (command_i == lbachs_pkg::CMD_INVALIDATE || zero_geom) begin
            state_d = lbachs_pkg::ST_OUTPUT;
          end else begin
            state_d = lbachs_pkg::ST_DIV_TRACK;
          end
        end
      end
      lbachs_pkg::ST_DIV_TRACK: begin
        if (cnt_done) begin
          state_d = lbachs_pkg::ST_CHECK;
        end
      end
      lbachs_pkg::ST_CHECK: begin
        if (!hit && beyond) begin
          state_d = lbachs_pkg::ST_OUTPUT;
        end else begin
          state_d = lbachs_pkg::ST_DIV_HEAD;
        end
      end
      lbachs_pkg::ST_DIV_HEAD: begin
        if (cnt_done) begin
          state_d = lbachs_pkg::ST_ASSEMBLE;
        end
      end
      lbachs_pkg::ST_ASSEMBLE: begin
        state_d = lbachs_pkg::ST_OUTPUT;
      end
      lbachs_pkg::ST_OUTPUT: begin
        if (out_load) begin
          state_d = lbachs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lbachs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lbachs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers. Writes leave the track cache alone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q       <= lbachs_pkg::SPT_RESET;
      heads_raw_q <= lbachs_pkg::HEADS_RESET;
      cyl_cnt_q   <= lbachs_pkg::CYL_RESET;
      drive_q     <= lbachs_pkg::DRIVE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lbachs_pkg::cfg_idx_e'(cfg_index_i))
        lbachs_pkg::CFG_SPT:   spt_q       <= cfg_data_i[lbachs_pkg::SPT_W-1:0];
        lbachs_pkg::CFG_HEADS: heads_raw_q <= cfg_data_i[lbachs_pkg::HEADS_W-1:0];
        lbachs_pkg::CFG_CYL:   cyl_cnt_q   <= cfg_data_i[lbachs_pkg::CYL_W-1:0];
        lbachs_pkg::CFG_DRIVE: drive_q     <= cfg_data_i[lbachs_pkg::DRIVE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Track cache. An in-range miss takes the new track on the assumption
  // that the track read succeeds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cached_track_q <= '0;
      cached_valid_q <= 1'b0;
    end else if (in_accept && command_i == lbachs_pkg::CMD_INVALIDATE) begin
      cached_valid_q <= 1'b0;
    end else if (state_q == lbachs_pkg::ST_CHECK && !hit && !beyond) begin
      cached_track_q <= dvd_q[lbachs_pkg::TRACK_W-1:0];
      cached_valid_q <= 1'b1;
    end
  end

  // Serial dividers and result assembly.
  always_ff @(posedge clk_i) begin
    case (state_q)
      lbachs_pkg::ST_IDLE: begin
        dvd_q   <= block_address_i[AddrW-1:0];
        rem1_q  <= '0;
        count_q <= sector_count_i;
        cnt_q   <= CntW'(AddrW - 1);
        // Invalidate and zero geometry answer at once with a fixed beat.
        res_cyl_q     <= '0;
        res_head_q    <= '0;
        res_sector_q  <= '0;
        res_dh_q      <= '0;
        res_granted_q <= '0;
        res_need_q    <= 1'b0;
        res_oor_q     <= (command_i == lbachs_pkg::CMD_TRANSLATE);
      end
      lbachs_pkg::ST_DIV_TRACK: begin
        rem1_q <= bit1 ? lbachs_pkg::SPT_W'(trial1 - {1'b0, spt_q})
                       : trial1[lbachs_pkg::SPT_W-1:0];
        dvd_q  <= {dvd_q[AddrW-2:0], bit1};
        cnt_q  <= cnt_q - CntW'(1);
      end
      lbachs_pkg::ST_CHECK: begin
        need_q    <= !hit;
        granted_q <= (count_q < left_ext) ? count_q : left_ext;
        trk_q     <= dvd_q[lbachs_pkg::TRACK_W-1:0];
        rem2_q    <= '0;
        cnt_q     <= CntW'(lbachs_pkg::TRACK_W - 1);
        res_oor_q <= 1'b1;  // only kept when the track is out of range
      end
      lbachs_pkg::ST_DIV_HEAD: begin
        rem2_q <= bit2 ? lbachs_pkg::HEAD_W'(trial2 - heads)
                       : trial2[lbachs_pkg::HEAD_W-1:0];
        trk_q  <= {trk_q[lbachs_pkg::TRACK_W-2:0], bit2};
        cnt_q  <= cnt_q - CntW'(1);
      end
      lbachs_pkg::ST_ASSEMBLE: begin
        res_cyl_q     <= trk_q[7:0];
        res_head_q    <= rem2_q;
        res_sector_q  <= rem1_q + lbachs_pkg::SPT_W'(1);
        res_dh_q      <= {2'b10, rem2_q, drive_q};
        res_granted_q <= granted_q;
        res_need_q    <= need_q;
        res_oor_q     <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Output register: holds the beat until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cyl_q     <= res_cyl_q;
      out_head_q    <= res_head_q;
      out_sector_q  <= res_sector_q;
      out_dh_q      <= res_dh_q;
      out_granted_q <= res_granted_q;
      out_need_q    <= res_need_q;
      out_oor_q     <= res_oor_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign cylinder_o          = out_cyl_q;
  assign head_o              = out_head_q;
  assign sector_o            = out_sector_q;
  assign drive_head_byte_o   = out_dh_q;
  assign granted_count_o     = out_granted_q;
  assign track_read_needed_o = out_need_q;
  assign out_of_range_o      = out_oor_q;

endmodule
